>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/core/lpma_pkg.sv
// ----------------------------------------------------------------------------
// lpma_pkg
// Shared types and constants of the lane point moving average.
// ----------------------------------------------------------------------------
package lpma_pkg;

  localparam int IN_W      = 12;  // input coordinate port width
  localparam int OUT_W     = 12;  // mean port width
  localparam int EXT_W     = 16;  // widest supported coordinate
  localparam int NUM_LANES = 4;

  localparam int LANE_LEFT_A  = 0;
  localparam int LANE_LEFT_B  = 1;
  localparam int LANE_RIGHT_A = 2;
  localparam int LANE_RIGHT_B = 3;

  typedef struct packed {
    logic done;        // lane idle, means are final
    logic has_points;  // window holds at least one point
  } lane_status_t;

endpackage

>>> rtl/core/lpma_ram.sv
// ----------------------------------------------------------------------------
// lpma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 20,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lpma_div.sv
// ----------------------------------------------------------------------------
// lpma_div
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpma_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NUM_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule

>>> rtl/core/lpma_lane.sv
// ----------------------------------------------------------------------------
// lpma_lane
// One endpoint window: history RAM, running sums, fill count and two
// serial dividers that produce the window's mean x and y.
// ----------------------------------------------------------------------------
module lpma_lane import lpma_pkg::*; #(
  parameter int WINDOW     = 20,
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  in_x,
  input  logic [IN_W-1:0]  in_y,
  output lane_status_t     status,
  output logic [OUT_W-1:0] mean_x,
  output logic [OUT_W-1:0] mean_y
);

  localparam int FW = $clog2(WINDOW + 1);
  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW = COORD_BITS + FW;
  localparam int CB = COORD_BITS;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_UPD  = 3'b010,
    L_DIV  = 3'b100
  } lane_state_t;

  lane_state_t state_r, state_nxt;

  logic [CB-1:0]   x_r, y_r;
  logic            pres_r;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [PW-1:0]   wpos_r, wpos_nxt;
  logic [SW-1:0]   sum_x_r, sum_x_nxt;
  logic [SW-1:0]   sum_y_r, sum_y_nxt;

  logic [EXT_W-1:0] x_ext, y_ext;
  logic [CB-1:0]    x_in, y_in;
  logic [2*CB-1:0]  old_pt;
  logic [CB-1:0]    old_x, old_y;
  logic             full;
  logic             upd;

  logic             div_x_busy, div_y_busy;
  logic [SW-1:0]    quo_x, quo_y;
  logic [SW+OUT_W-1:0] quo_x_ext, quo_y_ext;

  assign x_ext = {{(EXT_W-IN_W){1'b0}}, in_x};
  assign y_ext = {{(EXT_W-IN_W){1'b0}}, in_y};
  assign x_in  = x_ext[CB-1:0];
  assign y_in  = y_ext[CB-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:  if (start) state_nxt = L_UPD;
      L_UPD:   state_nxt = L_DIV;
      L_DIV:   if (!div_x_busy && !div_y_busy) state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x_in;
      y_r    <= y_in;
      pres_r <= (x_in != '0) || (y_in != '0);
    end
  end

  // Oldest entry is read at the write slot on the accept edge, used in L_UPD
  lpma_ram #(
    .WIDTH (2 * CB),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (upd),
    .waddr (wpos_r),
    .wdata ({y_r, x_r}),
    .re    (start),
    .raddr (wpos_r),
    .rdata (old_pt)
  );

  assign old_x = old_pt[CB-1:0];
  assign old_y = old_pt[2*CB-1:CB];
  assign full  = (fill_r == FW'(WINDOW));
  assign upd   = (state_r == L_UPD) && pres_r;

  always_comb begin
    fill_nxt  = fill_r;
    wpos_nxt  = wpos_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    if (upd) begin
      fill_nxt  = full ? fill_r : fill_r + 1'b1;
      wpos_nxt  = (wpos_r == PW'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;
      sum_x_nxt = sum_x_r + {{FW{1'b0}}, x_r} - (full ? {{FW{1'b0}}, old_x} : '0);
      sum_y_nxt = sum_y_r + {{FW{1'b0}}, y_r} - (full ? {{FW{1'b0}}, old_y} : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      wpos_r  <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      wpos_r  <= wpos_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
    end
  end

  lpma_div #(
    .NUM_W (SW),
    .DEN_W (FW)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == L_UPD),
    .num   (sum_x_nxt),
    .den   (fill_nxt),
    .busy  (div_x_busy),
    .quo   (quo_x)
  );

  lpma_div #(
    .NUM_W (SW),
    .DEN_W (FW)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == L_UPD),
    .num   (sum_y_nxt),
    .den   (fill_nxt),
    .busy  (div_y_busy),
    .quo   (quo_y)
  );

  assign quo_x_ext = {{OUT_W{1'b0}}, quo_x};
  assign quo_y_ext = {{OUT_W{1'b0}}, quo_y};

  // Empty window divides by zero; force the mean to zero instead
  assign mean_x = (fill_r != '0) ? quo_x_ext[OUT_W-1:0] : '0;
  assign mean_y = (fill_r != '0) ? quo_y_ext[OUT_W-1:0] : '0;

  assign status.done       = (state_r == L_IDLE);
  assign status.has_points = (fill_r != '0);

endmodule

>>> rtl/core/lane_point_moving_average.sv
// ----------------------------------------------------------------------------
// lane_point_moving_average
// Moving average of four lane endpoints over the last WINDOW found points,
// one lane per endpoint, merged into one registered result.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | four endpoints, x and y each
//  out_    | output    | out_valid/out_stall| eight means, tracking_valid
//
// One item at a time: after transfer each lane updates its window and runs its
// bit-serial dividers, and the merged result is then registered.
// in_stall is high from transfer until the result is in the output register.
// A finished result waits in the lanes while out_stall holds the previous one.
// Synchronous active-low reset clears counts, sums and handshake state; the
// history RAMs are not cleared and their data is used only after being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lane_point_moving_average import lpma_pkg::*; #(
  parameter int WINDOW     = 20,
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  in_left_a_x,
  input  logic [IN_W-1:0]  in_left_a_y,
  input  logic [IN_W-1:0]  in_left_b_x,
  input  logic [IN_W-1:0]  in_left_b_y,
  input  logic [IN_W-1:0]  in_right_a_x,
  input  logic [IN_W-1:0]  in_right_a_y,
  input  logic [IN_W-1:0]  in_right_b_x,
  input  logic [IN_W-1:0]  in_right_b_y,

  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_mean_left_a_x,
  output logic [OUT_W-1:0] out_mean_left_a_y,
  output logic [OUT_W-1:0] out_mean_left_b_x,
  output logic [OUT_W-1:0] out_mean_left_b_y,
  output logic [OUT_W-1:0] out_mean_right_a_x,
  output logic [OUT_W-1:0] out_mean_right_a_y,
  output logic [OUT_W-1:0] out_mean_right_b_x,
  output logic [OUT_W-1:0] out_mean_right_b_y,
  output logic             out_tracking_valid
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [IN_W-1:0]  lane_x [NUM_LANES];
  logic [IN_W-1:0]  lane_y [NUM_LANES];
  logic [OUT_W-1:0] lane_mx [NUM_LANES];
  logic [OUT_W-1:0] lane_my [NUM_LANES];
  lane_status_t     lane_st [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;

  logic in_xfer;
  logic out_free;
  logic load;
  logic track;

  logic             out_valid_r, out_valid_nxt;
  logic             track_r;
  logic [OUT_W-1:0] mx_r [NUM_LANES];
  logic [OUT_W-1:0] my_r [NUM_LANES];

  assign lane_x[LANE_LEFT_A]  = in_left_a_x;
  assign lane_y[LANE_LEFT_A]  = in_left_a_y;
  assign lane_x[LANE_LEFT_B]  = in_left_b_x;
  assign lane_y[LANE_LEFT_B]  = in_left_b_y;
  assign lane_x[LANE_RIGHT_A] = in_right_a_x;
  assign lane_y[LANE_RIGHT_A] = in_right_a_y;
  assign lane_x[LANE_RIGHT_B] = in_right_b_x;
  assign lane_y[LANE_RIGHT_B] = in_right_b_y;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lpma_lane #(
      .WINDOW     (WINDOW),
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (in_xfer),
      .in_x   (lane_x[g]),
      .in_y   (lane_y[g]),
      .status (lane_st[g]),
      .mean_x (lane_mx[g]),
      .mean_y (lane_my[g])
    );
    assign lane_done[g] = lane_st[g].done;
  end

  // Merge: means pass only when both first-endpoint windows hold points, else zero
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == S_BUSY) && (&lane_done) && out_free;
  assign track    = lane_st[LANE_LEFT_A].has_points && lane_st[LANE_RIGHT_A].has_points;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_BUSY;
      S_BUSY:  if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      track_r <= track;
      for (int i = 0; i < NUM_LANES; i++) begin
        mx_r[i] <= track ? lane_mx[i] : '0;
        my_r[i] <= track ? lane_my[i] : '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tracking_valid = track_r;
  assign out_mean_left_a_x  = mx_r[LANE_LEFT_A];
  assign out_mean_left_a_y  = my_r[LANE_LEFT_A];
  assign out_mean_left_b_x  = mx_r[LANE_LEFT_B];
  assign out_mean_left_b_y  = my_r[LANE_LEFT_B];
  assign out_mean_right_a_x = mx_r[LANE_RIGHT_A];
  assign out_mean_right_a_y = my_r[LANE_RIGHT_A];
  assign out_mean_right_b_x = mx_r[LANE_RIGHT_B];
  assign out_mean_right_b_y = my_r[LANE_RIGHT_B];

  `ASSERT_AT(a_xfer_then_busy, in_valid && !in_stall |=> in_stall, "input not held off after transfer")
  `ASSERT_AT(a_lanes_lockstep, lane_done == '0 || lane_done == '1, "lanes out of step")
  `ASSERT_AT(a_load_from_busy, $rose(out_valid) |-> $past(state_r == S_BUSY), "result without an item")
  `ASSERT_NEVER(a_untracked_zero, out_valid && !out_tracking_valid && (out_mean_left_a_x != '0 || out_mean_right_a_x != '0 || out_mean_left_b_y != '0 || out_mean_right_b_y != '0), "untracked result has nonzero means")

endmodule
